// ===== sv/dmac_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA controller package
// Types, action codes and register offsets shared by the controller modules.
// ----------------------------------------------------------------------------
package dmac_pkg;

   localparam int NumChannels = 4;

   typedef logic [1:0] chan_idx_type;
   typedef logic [NumChannels-1:0][15:0] word_array_type;
   typedef logic [NumChannels-1:0][7:0] byte_array_type;

   localparam logic [1:0] ActWrite = 2'd0;
   localparam logic [1:0] ActRead  = 2'd1;
   localparam logic [1:0] ActStart = 2'd2;
   localparam logic [1:0] ActStep  = 2'd3;

   localparam logic [4:0] AddrCtrlBase = 5'h10;
   localparam logic [4:0] AddrPriority = 5'h14;
   localparam logic [4:0] AddrIrq      = 5'h15;
   localparam logic [4:0] AddrChain    = 5'h16;

   localparam logic [1:0] SubAddrHigh  = 2'd0;
   localparam logic [1:0] SubAddrLow   = 2'd1;
   localparam logic [1:0] SubCountHigh = 2'd2;
   localparam logic [1:0] SubCountLow  = 2'd3;

   localparam logic [2:0] CfgMemOffset    = 3'd0;
   localparam logic [2:0] CfgDevAddr0     = 3'd1;
   localparam logic [2:0] CfgDevAddr1     = 3'd2;
   localparam logic [2:0] CfgDevAddr2     = 3'd3;
   localparam logic [2:0] CfgDevAddr3     = 3'd4;
   localparam logic [2:0] CfgChainEnable  = 3'd5;
   localparam logic [2:0] CfgMultiChain   = 3'd6;
   localparam logic [2:0] CfgSingleReads  = 3'd7;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] reg_addr;
      logic [7:0] write_data;
      logic [1:0] channel;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        xfer_valid;
      logic        to_memory;
      logic [19:0] mem_addr;
      logic [15:0] dev_addr;
      logic        start_taken;
      logic        channel_done;
      logic        irq;
   } rsp_type;

   typedef struct packed {
      logic [19:0]    mem_offset;
      word_array_type dev_addr;
      logic           chain_enable;
      logic           multi_chain_enable;
      logic           single_channel_reads;
   } cfg_type;

endpackage

// ===== sv/dmac_csr.sv =====
// ----------------------------------------------------------------------------
// DMA controller configuration registers
// APB-style register bank holding the memory offset, device addresses and
// chaining and read options.
// ----------------------------------------------------------------------------
module dmac_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output dmac_pkg::cfg_type cfg
);
   import dmac_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] index;

   assign index  = paddr[4:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mem_offset           <= '0;
         cfg_ff.dev_addr             <= '0;
         cfg_ff.chain_enable         <= 1'b1;
         cfg_ff.multi_chain_enable   <= 1'b1;
         cfg_ff.single_channel_reads <= 1'b0;
      end else if (wr_en) begin
         unique case (index)
            CfgMemOffset:   cfg_ff.mem_offset           <= pwdata[19:0];
            CfgDevAddr0:    cfg_ff.dev_addr[0]          <= pwdata[15:0];
            CfgDevAddr1:    cfg_ff.dev_addr[1]          <= pwdata[15:0];
            CfgDevAddr2:    cfg_ff.dev_addr[2]          <= pwdata[15:0];
            CfgDevAddr3:    cfg_ff.dev_addr[3]          <= pwdata[15:0];
            CfgChainEnable: cfg_ff.chain_enable         <= pwdata[0];
            CfgMultiChain:  cfg_ff.multi_chain_enable   <= pwdata[0];
            CfgSingleReads: cfg_ff.single_channel_reads <= pwdata[0];
            default:        cfg_ff.mem_offset           <= cfg_ff.mem_offset;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CfgMemOffset:   prdata = {12'd0, cfg_ff.mem_offset};
         CfgDevAddr0:    prdata = {16'd0, cfg_ff.dev_addr[0]};
         CfgDevAddr1:    prdata = {16'd0, cfg_ff.dev_addr[1]};
         CfgDevAddr2:    prdata = {16'd0, cfg_ff.dev_addr[2]};
         CfgDevAddr3:    prdata = {16'd0, cfg_ff.dev_addr[3]};
         CfgChainEnable: prdata = {31'd0, cfg_ff.chain_enable};
         CfgMultiChain:  prdata = {31'd0, cfg_ff.multi_chain_enable};
         CfgSingleReads: prdata = {31'd0, cfg_ff.single_channel_reads};
         default:        prdata = '0;
      endcase
   end

endmodule

// ===== sv/dmac_engine.sv =====
// ----------------------------------------------------------------------------
// DMA controller engine
// Channel register file and the combinational update for one registered item,
// with a registered result.
// ----------------------------------------------------------------------------
module dmac_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  dmac_pkg::req_type item,
   input  dmac_pkg::cfg_type cfg,
   output logic              rsp_valid,
   output dmac_pkg::rsp_type rsp
);
   import dmac_pkg::*;

   word_array_type        addr_ff, addr_in;
   word_array_type        count_ff, count_in;
   byte_array_type        control_ff, control_in;
   logic [NumChannels-1:0] active_ff, active_in;
   logic [7:0]            prio_ff, prio_in;
   logic [7:0]            irqc_ff, irqc_in;
   logic [7:0]            chain_ff, chain_in;
   logic                  irq_ff, irq_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;

   function automatic logic [7:0] irq_eval(input logic [7:0] irqc, input byte_array_type ctrl);
      logic [7:0] v;
      v = irqc;
      for (int i = 0; i < NumChannels; i++) begin
         if (irqc[i] && ctrl[i][7]) begin
            v[7] = 1'b1;
         end
      end
      return v;
   endfunction

   always_comb begin
      chan_idx_type   c_idx;
      chan_idx_type   k_idx;
      chan_idx_type   ch;
      chan_idx_type   rot_base;
      logic [15:0]    next_count;
      word_array_type step_addr;
      word_array_type step_count;

      c_idx      = item.reg_addr[3:2];
      k_idx      = item.reg_addr[1:0];
      ch         = item.channel;
      rot_base   = chain_ff[2:1];
      next_count = count_ff[ch] - 16'd1;
      step_addr  = addr_ff;
      step_count = count_ff;
      step_count[ch] = next_count;
      step_addr[ch]  = control_ff[ch][3] ? addr_ff[ch] - 16'd1 : addr_ff[ch] + 16'd1;

      addr_in    = addr_ff;
      count_in   = count_ff;
      control_in = control_ff;
      active_in  = active_ff;
      prio_in    = prio_ff;
      irqc_in    = irqc_ff;
      chain_in   = chain_ff;
      irq_in     = irq_ff;
      rsp_in     = '0;

      unique case (item.action)
         ActWrite: begin
            if (item.reg_addr < AddrCtrlBase) begin
               case (k_idx)
                  SubAddrHigh:  addr_in[c_idx][15:8]  = item.write_data;
                  SubAddrLow:   addr_in[c_idx][7:0]   = item.write_data;
                  SubCountHigh: count_in[c_idx][15:8] = item.write_data;
                  default:      count_in[c_idx][7:0]  = item.write_data;
               endcase
            end else if (item.reg_addr < AddrPriority) begin
               control_in[k_idx] = {control_ff[k_idx][7:6], 2'b00, item.write_data[3:0]};
            end else if (item.reg_addr == AddrPriority) begin
               prio_in = item.write_data & 8'h8F;
            end else if (item.reg_addr == AddrIrq) begin
               irqc_in = {irqc_ff[7], 3'b000, item.write_data[3:0]};
            end else if (item.reg_addr == AddrChain) begin
               chain_in = {chain_ff[7:4], item.write_data[3:0]};
            end
         end
         ActRead: begin
            if (cfg.single_channel_reads && item.reg_addr < AddrCtrlBase && c_idx != 2'd0) begin
               rsp_in.read_data = 8'h00;
            end else if (item.reg_addr < AddrCtrlBase) begin
               case (k_idx)
                  SubAddrHigh:  rsp_in.read_data = addr_ff[c_idx][15:8];
                  SubAddrLow:   rsp_in.read_data = addr_ff[c_idx][7:0];
                  SubCountHigh: rsp_in.read_data = count_ff[c_idx][15:8];
                  default:      rsp_in.read_data = count_ff[c_idx][7:0];
               endcase
            end else if (item.reg_addr < AddrPriority) begin
               rsp_in.read_data     = control_ff[k_idx];
               control_in[k_idx][7] = 1'b0;
            end else if (item.reg_addr == AddrPriority) begin
               rsp_in.read_data = prio_ff;
            end else if (item.reg_addr == AddrIrq) begin
               rsp_in.read_data = ({4'd0, chain_ff[7:4]} | 8'h80) & irqc_ff;
               irqc_in  = irq_eval({1'b0, irqc_ff[6:0]}, control_ff);
               chain_in = {4'd0, chain_ff[3:0]};
               irq_in   = irqc_in[7];
            end else if (item.reg_addr == AddrChain) begin
               rsp_in.read_data = {4'd0, chain_ff[3:0]};
            end else begin
               rsp_in.read_data = 8'hFF;
            end
         end
         ActStart: begin
            if (!active_ff[ch] && prio_ff[0] && count_ff[ch] != 16'd0) begin
               control_in[ch]     = {2'b01, 2'b00, control_ff[ch][3:0]};
               active_in[ch]      = 1'b1;
               rsp_in.start_taken = 1'b1;
            end
         end
         ActStep: begin
            if (active_ff[ch] && prio_ff[0]) begin
               if (count_ff[ch] == 16'd0) begin
                  active_in[ch]       = 1'b0;
                  control_in[ch]      = {2'b10, 2'b00, control_ff[ch][3:0]};
                  rsp_in.channel_done = 1'b1;
               end else begin
                  rsp_in.xfer_valid = 1'b1;
                  rsp_in.to_memory  = ~control_ff[ch][0];
                  rsp_in.mem_addr   = cfg.mem_offset + {4'd0, addr_ff[ch]};
                  rsp_in.dev_addr   = cfg.dev_addr[ch];
                  addr_in  = step_addr;
                  count_in = step_count;
                  if (next_count == 16'd0) begin
                     if (chain_ff[0] && cfg.chain_enable) begin
                        for (int i = 0; i < NumChannels; i++) begin
                           if (chain_ff[3] && cfg.multi_chain_enable) begin
                              if (chan_idx_type'(i) != rot_base + 2'd1) begin
                                 addr_in[i]  = step_addr[chan_idx_type'(i + 3)];
                                 count_in[i] = step_count[chan_idx_type'(i + 3)];
                              end else begin
                                 count_in[i] = 16'd0;
                              end
                           end else begin
                              if (chan_idx_type'(i) == rot_base) begin
                                 addr_in[i]  = step_addr[NumChannels-1];
                                 count_in[i] = step_count[NumChannels-1];
                              end
                              if (i == NumChannels - 1) begin
                                 count_in[i] = 16'd0;
                              end
                           end
                        end
                     end else begin
                        active_in[ch]       = 1'b0;
                        control_in[ch]      = {2'b10, 2'b00, control_ff[ch][3:0]};
                        chain_in            = chain_ff | 8'h10;
                        irqc_in             = irq_eval(irqc_ff, control_in);
                        irq_in              = irqc_in[7];
                        rsp_in.channel_done = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase

      rsp_in.irq = irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= {NumChannels{16'hFFFF}};
         count_ff     <= {NumChannels{16'hFFFF}};
         control_ff   <= '0;
         active_ff    <= '0;
         prio_ff      <= '0;
         irqc_ff      <= '0;
         chain_ff     <= '0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= item_valid;
         if (item_valid) begin
            addr_ff    <= addr_in;
            count_ff   <= count_in;
            control_ff <= control_in;
            active_ff  <= active_in;
            prio_ff    <= prio_in;
            irqc_ff    <= irqc_in;
            chain_ff   <= chain_in;
            irq_ff     <= irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sv/four_channel_dma_controller_top.sv =====
// ----------------------------------------------------------------------------
// Four-channel DMA controller
// Byte-wide register file, channel start and transfer-step sequencing.
// ----------------------------------------------------------------------------
// The request channel takes one command per cycle: a register write, a
// register read, a channel start or a transfer step. A command is taken at a
// rising edge with start high and busy low; busy is high only during reset.
// Each command produces exactly one response. The response is shown for one
// cycle with rsp_strobe high, after the command has passed the item register
// and the engine's response register. A new command
// may be taken every cycle, so the throughput is one command per cycle; the
// command is registered, applied to the channel registers in one cycle, and
// the response is registered.
// The receiver cannot stall the response channel and must take each
// response in the cycle it is shown.
// The configuration port sets the memory offset, device addresses, chaining
// and read options; the user must write it only while no command is in
// flight; the block does not enforce this. Reset restores all channel
// registers and configuration to defaults and drops any command in flight.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic [1:0]  req_channel,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_xfer_valid,
   output logic        rsp_to_memory,
   output logic [19:0] rsp_mem_addr,
   output logic [15:0] rsp_dev_addr,
   output logic        rsp_start_taken,
   output logic        rsp_channel_done,
   output logic        rsp_irq,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import dmac_pkg::*;

   req_type item_ff;
   logic    item_valid_ff;
   cfg_type cfg;
   rsp_type rsp;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         item_ff.action     <= req_action;
         item_ff.reg_addr   <= req_reg_addr;
         item_ff.write_data <= req_write_data;
         item_ff.channel    <= req_channel;
      end
   end

   dmac_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dmac_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .cfg        (cfg),
      .rsp_valid  (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_read_data    = rsp.read_data;
   assign rsp_xfer_valid   = rsp.xfer_valid;
   assign rsp_to_memory    = rsp.to_memory;
   assign rsp_mem_addr     = rsp.mem_addr;
   assign rsp_dev_addr     = rsp.dev_addr;
   assign rsp_start_taken  = rsp.start_taken;
   assign rsp_channel_done = rsp.channel_done;
   assign rsp_irq          = rsp.irq;

   a_rsp_follows_cmd : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("Response without a command taken two cycles earlier.");

   a_xfer_only_on_step : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_xfer_valid) |-> $past(req_action == ActStep, 2))
      else $error("Transfer reported for a command that is not a step.");

   a_data_only_on_read : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_read_data != 8'd0) |-> $past(req_action == ActRead, 2))
      else $error("Read data reported for a command that is not a read.");

endmodule

// ===== tb/four_channel_dma_controller_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Four-channel DMA controller testbench
// Drives register accesses, channel starts and transfer steps into the
// controller, predicts every response from a shadow copy of the channel
// registers and configuration, and compares each response field by field.
// Directed tests cover reset values, start rules, completion, interrupts,
// chaining and the read options; three random phases follow, each under a
// different configuration and a different amount of sender idling.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_top_test;
   import dmac_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [4:0]  req_reg_addr = '0;
   logic [7:0]  req_write_data = '0;
   logic [1:0]  req_channel = '0;
   logic        rsp_strobe;
   logic [7:0]  rsp_read_data;
   logic        rsp_xfer_valid;
   logic        rsp_to_memory;
   logic [19:0] rsp_mem_addr;
   logic [15:0] rsp_dev_addr;
   logic        rsp_start_taken;
   logic        rsp_channel_done;
   logic        rsp_irq;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   four_channel_dma_controller_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_reg_addr     (req_reg_addr),
      .req_write_data   (req_write_data),
      .req_channel      (req_channel),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_data    (rsp_read_data),
      .rsp_xfer_valid   (rsp_xfer_valid),
      .rsp_to_memory    (rsp_to_memory),
      .rsp_mem_addr     (rsp_mem_addr),
      .rsp_dev_addr     (rsp_dev_addr),
      .rsp_start_taken  (rsp_start_taken),
      .rsp_channel_done (rsp_channel_done),
      .rsp_irq          (rsp_irq),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   rsp_type pending_responses[$];
   int      mismatch_count = 0;
   int      counted_items = 0;
   int      idle_pct = 0;

   cfg_type     shadow_cfg;
   logic [15:0] shadow_addr [NumChannels];
   logic [15:0] shadow_count [NumChannels];
   logic [7:0]  shadow_ctrl [NumChannels];
   logic        shadow_active [NumChannels];
   logic [7:0]  shadow_priority;
   logic [7:0]  shadow_irq_ctrl;
   logic [7:0]  shadow_chain;
   logic        shadow_irq_line;

   function automatic void reset_shadow();
      shadow_cfg = '0;
      shadow_cfg.chain_enable = 1'b1;
      shadow_cfg.multi_chain_enable = 1'b1;
      for (int i = 0; i < NumChannels; i++) begin
         shadow_addr[i] = 16'hFFFF;
         shadow_count[i] = 16'hFFFF;
         shadow_ctrl[i] = '0;
         shadow_active[i] = 1'b0;
      end
      shadow_priority = '0;
      shadow_irq_ctrl = '0;
      shadow_chain = '0;
      shadow_irq_line = 1'b0;
   endfunction

   // The flag is only ever set here; an interrupt register read clears it and then calls this.
   function automatic void update_irq_flag();
      for (int i = 0; i < NumChannels; i++) begin
         if (shadow_irq_ctrl[i] && shadow_ctrl[i][7]) begin
            shadow_irq_ctrl[7] = 1'b1;
         end
      end
      shadow_irq_line = shadow_irq_ctrl[7];
   endfunction

   function automatic void apply_reg_write(input logic [4:0] a, input logic [7:0] d);
      logic [1:0] c;
      c = a[3:2];
      if (a < AddrCtrlBase) begin
         case (a[1:0])
            SubAddrHigh:  shadow_addr[c][15:8] = d;
            SubAddrLow:   shadow_addr[c][7:0] = d;
            SubCountHigh: shadow_count[c][15:8] = d;
            default:      shadow_count[c][7:0] = d;
         endcase
      end else if (a < AddrPriority) begin
         shadow_ctrl[a[1:0]] = {shadow_ctrl[a[1:0]][7:6], 2'b00, d[3:0]};
      end else if (a == AddrPriority) begin
         shadow_priority = {d[7], 3'b000, d[3:0]};
      end else if (a == AddrIrq) begin
         shadow_irq_ctrl = {shadow_irq_ctrl[7], 3'b000, d[3:0]};
      end else if (a == AddrChain) begin
         shadow_chain = {shadow_chain[7:4], d[3:0]};
      end
   endfunction

   function automatic logic [7:0] apply_reg_read(input logic [4:0] a);
      logic [1:0] c;
      logic [7:0] r;
      c = a[3:2];
      r = 8'hFF;
      if (shadow_cfg.single_channel_reads && a < AddrPriority && c != 2'd0) begin
         return 8'h00;
      end
      if (a < AddrCtrlBase) begin
         case (a[1:0])
            SubAddrHigh:  r = shadow_addr[c][15:8];
            SubAddrLow:   r = shadow_addr[c][7:0];
            SubCountHigh: r = shadow_count[c][15:8];
            default:      r = shadow_count[c][7:0];
         endcase
      end else if (a < AddrPriority) begin
         r = shadow_ctrl[a[1:0]];
         shadow_ctrl[a[1:0]][7] = 1'b0;
      end else if (a == AddrPriority) begin
         r = shadow_priority;
      end else if (a == AddrIrq) begin
         r = ({4'b0000, shadow_chain[7:4]} | 8'h80) & shadow_irq_ctrl;
         shadow_irq_ctrl[7] = 1'b0;
         shadow_chain[7:4] = 4'b0000;
         update_irq_flag();
      end else if (a == AddrChain) begin
         r = {4'b0000, shadow_chain[3:0]};
      end
      return r;
   endfunction

   function automatic void apply_chain();
      logic [1:0] c;
      logic [1:0] p1;
      logic [1:0] p2;
      logic [1:0] p3;
      c = shadow_chain[2:1];
      p1 = c + 2'd1;
      p2 = c + 2'd2;
      p3 = c + 2'd3;
      if (shadow_chain[3] && shadow_cfg.multi_chain_enable) begin
         shadow_addr[c] = shadow_addr[p3];
         shadow_addr[p3] = shadow_addr[p2];
         shadow_addr[p2] = shadow_addr[p1];
         shadow_count[c] = shadow_count[p3];
         shadow_count[p3] = shadow_count[p2];
         shadow_count[p2] = shadow_count[p1];
         shadow_count[p1] = 16'h0000;
      end else begin
         shadow_addr[c] = shadow_addr[3];
         shadow_count[c] = shadow_count[3];
         shadow_count[3] = 16'h0000;
      end
   endfunction

   function automatic rsp_type predict_dma_response(input req_type cmd);
      rsp_type    r;
      logic [1:0] ch;
      ch = cmd.channel;
      r = '0;
      case (cmd.action)
         ActWrite: apply_reg_write(cmd.reg_addr, cmd.write_data);
         ActRead:  r.read_data = apply_reg_read(cmd.reg_addr);
         ActStart: begin
            if (!shadow_active[ch] && shadow_priority[0] && shadow_count[ch] != 16'h0000) begin
               shadow_ctrl[ch] = {2'b01, 2'b00, shadow_ctrl[ch][3:0]};
               shadow_active[ch] = 1'b1;
               r.start_taken = 1'b1;
            end
         end
         default: begin
            if (shadow_active[ch] && shadow_priority[0]) begin
               if (shadow_count[ch] == 16'h0000) begin
                  shadow_active[ch] = 1'b0;
                  shadow_ctrl[ch] = {2'b10, 2'b00, shadow_ctrl[ch][3:0]};
                  r.channel_done = 1'b1;
               end else begin
                  r.xfer_valid = 1'b1;
                  r.to_memory = ~shadow_ctrl[ch][0];
                  r.mem_addr = {4'h0, shadow_addr[ch]} + shadow_cfg.mem_offset;
                  r.dev_addr = shadow_cfg.dev_addr[ch];
                  shadow_count[ch] = shadow_count[ch] - 16'd1;
                  if (shadow_ctrl[ch][3]) begin
                     shadow_addr[ch] = shadow_addr[ch] - 16'd1;
                  end else begin
                     shadow_addr[ch] = shadow_addr[ch] + 16'd1;
                  end
                  if (shadow_count[ch] == 16'h0000) begin
                     if (shadow_chain[0] && shadow_cfg.chain_enable) begin
                        apply_chain();
                     end else begin
                        shadow_active[ch] = 1'b0;
                        shadow_ctrl[ch] = {2'b10, 2'b00, shadow_ctrl[ch][3:0]};
                        shadow_chain[4] = 1'b1;
                        update_irq_flag();
                        r.channel_done = 1'b1;
                     end
                  end
               end
            end
         end
      endcase
      r.irq = shadow_irq_line;
      return r;
   endfunction

   always @(negedge clock) begin : response_checker
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = {rsp_read_data, rsp_xfer_valid, rsp_to_memory, rsp_mem_addr, rsp_dev_addr,
                rsp_start_taken, rsp_channel_done, rsp_irq};
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: response with no command outstanding", $realtime);
            end
         end else begin
            want = pending_responses.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response mismatch (expected / actual)", $realtime);
                  $display("   read_data %h / %h  xfer_valid %b / %b  to_memory %b / %b",
                           want.read_data, got.read_data, want.xfer_valid, got.xfer_valid,
                           want.to_memory, got.to_memory);
                  $display("   mem_addr %h / %h  dev_addr %h / %h", want.mem_addr,
                           got.mem_addr, want.dev_addr, got.dev_addr);
                  $display("   start_taken %b / %b  channel_done %b / %b  irq %b / %b",
                           want.start_taken, got.start_taken, want.channel_done,
                           got.channel_done, want.irq, got.irq);
               end
            end
         end
      end
   end

   // Called just after a rising edge; returns just after the edge that takes the command.
   task automatic send_command(input logic [1:0] action, input logic [4:0] addr,
                               input logic [7:0] data, input logic [1:0] chan);
      req_type cmd;
      rsp_type want;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= action;
      req_reg_addr <= addr;
      req_write_data <= data;
      req_channel <= chan;
      do @(negedge clock); while (busy !== 1'b0);
      cmd.action = action;
      cmd.reg_addr = addr;
      cmd.write_data = data;
      cmd.channel = chan;
      want = predict_dma_response(cmd);
      pending_responses.push_back(want);
      counted_items++;
      @(posedge clock);
   endtask

   task automatic wait_for_responses();
      start <= 1'b0;
      while (pending_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_config(input logic [2:0] index, input logic [31:0] value);
      wait_for_responses();
      repeat (2) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CfgMemOffset:   shadow_cfg.mem_offset = value[19:0];
         CfgDevAddr0:    shadow_cfg.dev_addr[0] = value[15:0];
         CfgDevAddr1:    shadow_cfg.dev_addr[1] = value[15:0];
         CfgDevAddr2:    shadow_cfg.dev_addr[2] = value[15:0];
         CfgDevAddr3:    shadow_cfg.dev_addr[3] = value[15:0];
         CfgChainEnable: shadow_cfg.chain_enable = value[0];
         CfgMultiChain:  shadow_cfg.multi_chain_enable = value[0];
         default:        shadow_cfg.single_channel_reads = value[0];
      endcase
   endtask

   task automatic test_register_file();
      send_command(ActRead, {1'b0, 2'd0, SubAddrHigh}, 8'h00, 2'd0);
      send_command(ActWrite, 5'h1F, 8'hAA, 2'd3);
      send_command(ActRead, 5'h1F, 8'hFF, 2'd3);
      send_command(ActWrite, AddrPriority, 8'hFE, 2'd0);
      send_command(ActRead, AddrPriority, 8'h00, 2'd0);
   endtask

   task automatic test_start_and_transfer();
      send_command(ActStart, 5'h00, 8'h00, 2'd0);
      send_command(ActWrite, AddrPriority, 8'h01, 2'd0);
      send_command(ActWrite, {1'b0, 2'd0, SubCountHigh}, 8'h00, 2'd0);
      send_command(ActWrite, {1'b0, 2'd0, SubCountLow}, 8'h02, 2'd0);
      send_command(ActWrite, AddrCtrlBase, 8'hF9, 2'd0);
      send_command(ActWrite, AddrIrq, 8'hFF, 2'd0);
      send_command(ActStart, 5'h1F, 8'hFF, 2'd0);
      send_command(ActStart, 5'h00, 8'h00, 2'd0);
      send_command(ActStep, 5'h00, 8'h00, 2'd1);
      send_command(ActStep, 5'h00, 8'h00, 2'd0);
      send_command(ActStep, 5'h00, 8'h00, 2'd0);
      send_command(ActRead, AddrIrq, 8'h00, 2'd0);
      send_command(ActRead, AddrCtrlBase, 8'h00, 2'd0);
      send_command(ActRead, AddrIrq, 8'h00, 2'd0);
   endtask

   task automatic test_chaining();
      send_command(ActWrite, AddrChain, 8'h03, 2'd0);
      send_command(ActWrite, {1'b0, 2'd1, SubCountHigh}, 8'h00, 2'd0);
      send_command(ActWrite, {1'b0, 2'd1, SubCountLow}, 8'h01, 2'd0);
      send_command(ActStart, 5'h00, 8'h00, 2'd1);
      send_command(ActStep, 5'h00, 8'h00, 2'd1);
      send_command(ActStart, 5'h00, 8'h00, 2'd3);
      send_command(ActWrite, {1'b0, 2'd1, SubCountHigh}, 8'h00, 2'd0);
      send_command(ActWrite, {1'b0, 2'd1, SubCountLow}, 8'h00, 2'd0);
      send_command(ActStep, 5'h00, 8'h00, 2'd1);
      send_command(ActWrite, AddrChain, 8'h0B, 2'd0);
      send_command(ActWrite, {1'b0, 2'd2, SubCountLow}, 8'h01, 2'd0);
      send_command(ActStart, 5'h00, 8'h00, 2'd2);
      send_command(ActStep, 5'h00, 8'h00, 2'd2);
   endtask

   task automatic test_read_options();
      set_config(CfgSingleReads, 32'd1);
      send_command(ActRead, {1'b0, 2'd1, SubAddrLow}, 8'h00, 2'd0);
      send_command(ActRead, AddrCtrlBase | 5'd1, 8'h00, 2'd0);
      set_config(CfgSingleReads, 32'd0);
   endtask

   task automatic program_channel(input logic [1:0] ch);
      logic [7:0] value;
      send_command(ActWrite, {1'b0, ch, SubAddrHigh}, 8'($urandom), 2'($urandom));
      send_command(ActWrite, {1'b0, ch, SubAddrLow}, 8'($urandom), 2'($urandom));
      value = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00;
      send_command(ActWrite, {1'b0, ch, SubCountHigh}, value, 2'($urandom));
      send_command(ActWrite, {1'b0, ch, SubCountLow}, 8'($urandom_range(0, 8)),
                   2'($urandom));
      send_command(ActWrite, AddrCtrlBase | {3'b000, ch}, 8'($urandom), 2'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         value = 8'($urandom);
         if ($urandom_range(0, 7) != 0) begin
            value[0] = 1'b1;
         end
         send_command(ActWrite, AddrPriority, value, 2'($urandom));
      end
      send_command(ActStart, 5'($urandom), 8'($urandom), ch);
   endtask

   task automatic test_random_traffic(input int target, input int pct);
      int         first;
      int         k;
      logic [1:0] ch;
      logic [4:0] addr;
      idle_pct = pct;
      first = counted_items;
      while (counted_items - first < target) begin
         ch = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1: send_command(2'($urandom), 5'($urandom), 8'($urandom), 2'($urandom));
            2, 3, 4: program_channel(ch);
            5, 6, 7: begin
               for (k = 0; k < NumChannels && !shadow_active[ch]; k++) begin
                  ch = ch + 2'd1;
               end
               repeat ($urandom_range(1, 8)) begin
                  send_command(ActStep, 5'($urandom), 8'($urandom), ch);
               end
            end
            8: begin
               send_command(ActWrite, AddrChain, 8'($urandom), 2'($urandom));
               send_command(ActWrite, AddrIrq, 8'($urandom), 2'($urandom));
            end
            default: begin
               addr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(16, 22));
               send_command(ActRead, addr, 8'($urandom), 2'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      reset_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 23;
      test_register_file();
      test_start_and_transfer();
      test_chaining();
      test_read_options();

      set_config(CfgMemOffset, 32'd983040);
      set_config(CfgDevAddr0, 32'h0000);
      set_config(CfgDevAddr1, 32'hFFFF);
      set_config(CfgDevAddr2, $urandom_range(0, 65535));
      set_config(CfgDevAddr3, $urandom_range(0, 65535));
      test_random_traffic(617, 23);

      set_config(CfgMemOffset, 32'd0);
      set_config(CfgDevAddr0, 32'hFFFF);
      set_config(CfgDevAddr2, 32'h0000);
      set_config(CfgChainEnable, 32'd0);
      set_config(CfgSingleReads, 32'd1);
      test_random_traffic(617, 78);

      set_config(CfgMemOffset, $urandom_range(0, 983040));
      set_config(CfgDevAddr3, 32'hFFFF);
      set_config(CfgChainEnable, 32'd1);
      set_config(CfgMultiChain, 32'd0);
      set_config(CfgSingleReads, $urandom_range(0, 1));
      test_random_traffic(617, 0);

      wait_for_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dmac_pkg.sv
sv/dmac_csr.sv
sv/dmac_engine.sv
sv/four_channel_dma_controller_top.sv
tb/four_channel_dma_controller_top_test.sv
